// File: rtl/rqs_pkg.sv
// shared types and codes for the request queue and its cells
package rqs_pkg;

    localparam int TAG_W  = 16;
    localparam int SIZE_W = 31;
    localparam int OCC_W  = 5;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    localparam logic POLICY_FCFS = 1'b0;
    localparam logic POLICY_SJF  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_GRANT
    } state_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    typedef struct packed {
        logic enq_en;
        logic shift_en;
        logic scan_en;
    } cell_ctl_t;

    typedef struct packed {
        logic [OCC_W-1:0]  occupancy;
        status_t           status;
        logic              grant_valid;
        logic [SIZE_W-1:0] size;
        logic [TAG_W-1:0]  tag;
    } result_t;

endpackage

// File: rtl/rqs_cell.sv
// one queue slot: holds an entry, shifts toward the head, carries the suffix minimum
module rqs_cell #(
    parameter int QUEUE_DEPTH = 16,
    parameter int CELL_IDX    = 0,
    localparam int IDX_W = $clog2(QUEUE_DEPTH),
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                 clk,
    input  rqs_pkg::cell_ctl_t   ctl,
    input  logic [CNT_W-1:0]     count,
    input  logic [IDX_W-1:0]     grant_idx,
    input  rqs_pkg::entry_t      in_entry,
    input  rqs_pkg::entry_t      right_entry,
    input  rqs_pkg::entry_t      right_scan,
    input  logic [IDX_W-1:0]     right_scan_idx,
    output rqs_pkg::entry_t      entry,
    output rqs_pkg::entry_t      scan,
    output logic [IDX_W-1:0]     scan_idx
);
    import rqs_pkg::*;

    localparam logic [CNT_W-1:0] MY_POS   = CNT_W'(CELL_IDX);
    localparam logic [CNT_W-1:0] NEXT_POS = CNT_W'(CELL_IDX + 1);
    localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(CELL_IDX);

    entry_t            entry_reg, entry_next;
    entry_t            scan_reg, scan_next;
    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              has_right;
    logic              take_right;

    assign has_right  = NEXT_POS < count;
    // strict compare keeps the entry nearest the head on a tie
    assign take_right = has_right && (right_scan.size < entry_reg.size);

    always_comb
    begin
        entry_next    = entry_reg;
        scan_next     = scan_reg;
        scan_idx_next = scan_idx_reg;
        if (ctl.enq_en && (count == MY_POS))
        begin
            entry_next = in_entry;
        end
        else if (ctl.shift_en && (MY_IDX >= grant_idx) && has_right)
        begin
            entry_next = right_entry;
        end
        if (ctl.scan_en)
        begin
            if (take_right)
            begin
                scan_next     = right_scan;
                scan_idx_next = right_scan_idx;
            end
            else
            begin
                scan_next     = entry_reg;
                scan_idx_next = MY_IDX;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg    <= entry_next;
        scan_reg     <= scan_next;
        scan_idx_reg <= scan_idx_next;
    end

    assign entry    = entry_reg;
    assign scan     = scan_reg;
    assign scan_idx = scan_idx_reg;

endmodule

// File: rtl/request_queue_fcfs_sjf.sv
// top level of the pending-request queue with first-come or shortest-first grant
// Requests sit in a row of cells in arrival order, the head in cell 0. An enqueue,
// a first-come dequeue, a drop on a full queue and a dequeue on an empty queue are
// each handled in the idle state, so such items stream at one per cycle while the result
// side drains. A shortest-first dequeue walks the running minimum from the tail cell
// toward cell 0 one cell per cycle in the scan state, then the grant state grants and
// closes the gap. One result beat is returned per input beat, and a spare result slot
// lets the next input beat in while a result waits.
module request_queue_fcfs_sjf #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // request_tag[15:0], job_size[46:16], zero pad
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // granted_tag[15:0], granted_size[46:16], occupancy[51:47]
    output logic [2:0]  m_tuser,   // grant_valid[0], status[2:1]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data   // policy_select
);
    import rqs_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic              policy_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    logic              skid_valid_reg;
    result_t           skid_reg;

    logic              accept;
    logic              is_deq;
    logic              is_full;
    logic              is_empty;
    logic              out_free;
    logic              out_pop;
    logic              load_out;
    result_t           result;
    cell_ctl_t         ctl;
    logic [IDX_W-1:0]  grant_idx;
    entry_t            in_entry;

    entry_t            cell_entry [QUEUE_DEPTH];
    entry_t            cell_scan  [QUEUE_DEPTH];
    logic [IDX_W-1:0]  cell_idx   [QUEUE_DEPTH];

    assign in_entry.tag  = s_tdata[15:0];
    assign in_entry.size = s_tdata[46:16];

    // room for one more result as long as the spare slot is empty
    assign out_free = !skid_valid_reg;
    assign out_pop  = out_valid_reg && m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign is_deq   = (s_tuser == MODE_DEQ);
    assign is_full  = (count_reg == FULL_CNT);
    assign is_empty = (count_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_deq && !is_empty && (policy_reg == POLICY_SJF))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_GRANT;
                end
            end
            ST_GRANT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // cell control, count and result
    always_comb
    begin
        ctl            = '0;
        grant_idx      = '0;
        count_next     = count_reg;
        scan_cnt_next  = scan_cnt_reg;
        load_out       = 1'b0;
        result         = '0;
        result.status  = STATUS_OK;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!is_deq)
                    begin
                        load_out = 1'b1;
                        if (is_full)
                        begin
                            result.status = STATUS_FULL;
                        end
                        else
                        begin
                            ctl.enq_en = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (is_empty)
                    begin
                        load_out      = 1'b1;
                        result.status = STATUS_EMPTY;
                    end
                    else if (policy_reg == POLICY_FCFS)
                    begin
                        load_out           = 1'b1;
                        ctl.shift_en       = 1'b1;
                        count_next         = count_reg - CNT_W'(1);
                        result.grant_valid = 1'b1;
                        result.tag         = cell_entry[0].tag;
                        result.size        = cell_entry[0].size;
                    end
                    else
                    begin
                        scan_cnt_next = count_reg;
                    end
                end
            end
            ST_SCAN:
            begin
                ctl.scan_en   = 1'b1;
                scan_cnt_next = scan_cnt_reg - CNT_W'(1);
            end
            ST_GRANT:
            begin
                grant_idx = cell_idx[0];
                if (out_free)
                begin
                    load_out           = 1'b1;
                    ctl.shift_en       = 1'b1;
                    count_next         = count_reg - CNT_W'(1);
                    result.grant_valid = 1'b1;
                    result.tag         = cell_scan[0].tag;
                    result.size        = cell_scan[0].size;
                end
            end
            default:
            begin
                ctl = '0;
            end
        endcase
        result.occupancy = OCC_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            scan_cnt_reg   <= '0;
            policy_reg     <= POLICY_FCFS;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_cnt_reg <= scan_cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                policy_reg <= cfg_data[0];
            end
            if (out_pop)
            begin
                out_valid_reg  <= skid_valid_reg || load_out;
                skid_valid_reg <= 1'b0;
            end
            else if (load_out)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= out_valid_reg;
            end
        end
    end

    // two-slot result buffer: head drives the port, spare takes a beat while head waits
    always_ff @(posedge clk)
    begin
        if (out_pop)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (load_out)
            begin
                out_reg <= result;
            end
        end
        else if (load_out)
        begin
            if (out_valid_reg)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {4'b0, out_reg.occupancy, out_reg.size, out_reg.tag};
    assign m_tuser   = {out_reg.status, out_reg.grant_valid};

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            entry_t           right_entry;
            entry_t           right_scan;
            logic [IDX_W-1:0] right_idx;
            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_entry = '0;
                assign right_scan  = '0;
                assign right_idx   = '0;
            end
            else
            begin : g_link
                assign right_entry = cell_entry[gi + 1];
                assign right_scan  = cell_scan[gi + 1];
                assign right_idx   = cell_idx[gi + 1];
            end
            rqs_cell #(
                .QUEUE_DEPTH (QUEUE_DEPTH),
                .CELL_IDX    (gi)
            ) u_cell (
                .clk            (clk),
                .ctl            (ctl),
                .count          (count_reg),
                .grant_idx      (grant_idx),
                .in_entry       (in_entry),
                .right_entry    (right_entry),
                .right_scan     (right_scan),
                .right_scan_idx (right_idx),
                .entry          (cell_entry[gi]),
                .scan           (cell_scan[gi]),
                .scan_idx       (cell_idx[gi])
            );
        end
    endgenerate

    // occupancy never passes the number of cells
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("occupancy beyond queue depth");

    // the minimum walk leaves the entry count alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> (count_reg == $past(count_reg)))
        else $error("count changed during scan");

    // the shortest-first pick is a held entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GRANT) |-> (CNT_W'(cell_idx[0]) < count_reg))
        else $error("granted index outside held entries");

    // a granted beat always carries ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tuser[2:1] == STATUS_OK))
        else $error("grant with error status");

endmodule

// File: tb/request_queue_fcfs_sjf_tb.sv
// testbench for the pending-request queue with first-come and shortest-first grant
`timescale 1ns / 100ps

module request_queue_fcfs_sjf_tb;

    import rqs_pkg::*;

    localparam int DEPTH         = 16;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // request_tag[15:0], job_size[46:16], zero pad
    logic        s_tuser;   // mode
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // granted_tag[15:0], granted_size[46:16], occupancy[51:47]
    logic [2:0]  m_tuser;   // grant_valid[0], status[2:1]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_data;  // policy_select

    // predictor state
    logic [TAG_W-1:0]  held_tag [DEPTH];
    logic [SIZE_W-1:0] held_size[DEPTH];
    int                held_count;
    logic              grant_policy;

    result_t expected_beats[$];
    int      mismatches;
    int      cycle_count;
    int      hold_left;
    bit      sender_idle_on;
    bit      receiver_idle_on;

    request_queue_fcfs_sjf #(
        .QUEUE_DEPTH(DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off counted down here
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (receiver_idle_on)
            m_tready <= ($urandom_range(0, 99) >= 18);
        else
            m_tready <= 1'b1;
    end

    // apply one request to the predicted queue and work out its result beat
    task automatic predict_request(input logic mode, input logic [TAG_W-1:0] tag,
                                   input logic [SIZE_W-1:0] size, output result_t beat);
        int pick;
        beat = '0;
        beat.status = STATUS_OK;
        if (mode == MODE_ENQ)
        begin
            if (held_count >= DEPTH)
                beat.status = STATUS_FULL;
            else
            begin
                held_tag[held_count]  = tag;
                held_size[held_count] = size;
                held_count++;
            end
        end
        else if (held_count == 0)
            beat.status = STATUS_EMPTY;
        else
        begin
            pick = 0;
            if (grant_policy == POLICY_SJF)
            begin
                for (int i = 1; i < held_count; i++)
                    if (held_size[i] < held_size[pick])
                        pick = i;
            end
            beat.grant_valid = 1'b1;
            beat.tag  = held_tag[pick];
            beat.size = held_size[pick];
            for (int i = pick; i + 1 < held_count; i++)
            begin
                held_tag[i]  = held_tag[i + 1];
                held_size[i] = held_size[i + 1];
            end
            held_count--;
        end
        beat.occupancy = held_count[OCC_W-1:0];
    endtask

    // entered and left at a falling edge; holds the beat until accepted
    task automatic send_request(input logic mode, input logic [TAG_W-1:0] tag,
                                input logic [SIZE_W-1:0] size);
        result_t beat;
        if (sender_idle_on && $urandom_range(0, 99) < 18)
        begin
            s_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < 18);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, size, tag};
        do
            @(posedge clk);
        while (!s_tready);
        predict_request(mode, tag, size, beat);
        expected_beats.push_back(beat);
        @(negedge clk);
    endtask

    // register writes only with all expected results drained and the block settled
    task automatic write_policy(input logic policy);
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= policy;
        do
            @(posedge clk);
        while (!cfg_ready);
        grant_policy = policy;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SIZE_W-1:0] random_size();
        logic [SIZE_W-1:0] size;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: size = SIZE_W'($urandom_range(0, 7));   // many ties
            4:          size = $urandom_range(0, 1) ? SIZE_MAX : '0;
            default:    size = SIZE_W'($urandom);
        endcase
        return size;
    endfunction

    task automatic run_random_burst(input int count, input int enq_pct);
        logic mode;
        repeat (count)
        begin
            mode = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
            send_request(mode, TAG_W'($urandom_range(0, 65535)), random_size());
        end
    endtask

    // bursts that lean toward filling or draining, so full and empty come up often
    task automatic run_random_traffic(input int total);
        int sent;
        int count;
        int enq_pct;
        sent = 0;
        while (sent < total)
        begin
            count = $urandom_range(20, 40);
            case ($urandom_range(0, 3))
                0:       enq_pct = 25;
                1:       enq_pct = 50;
                2:       enq_pct = 75;
                default: enq_pct = 90;
            endcase
            run_random_burst(count, enq_pct);
            sent += count;
        end
    endtask

    task automatic test_directed();
        write_policy(POLICY_FCFS);
        send_request(MODE_DEQ, 16'hFFFF, SIZE_MAX);     // dequeue on empty
        send_request(MODE_ENQ, 16'h0000, '0);
        send_request(MODE_ENQ, 16'hFFFF, SIZE_MAX);
        send_request(MODE_DEQ, 16'h1234, 31'h1234);     // head granted
        // fill to the brim, smallest size three times over
        for (int i = 1; i < DEPTH; i++)
            send_request(MODE_ENQ, 16'h0100 + 16'(i),
                         (i == 3 || i == 7 || i == 11) ? 31'd3 : 31'd1000 - 31'(i));
        send_request(MODE_ENQ, 16'hABCD, 31'd1);        // dropped, queue full
        write_policy(POLICY_SJF);
        repeat (3) send_request(MODE_DEQ, '0, '0);      // ties go to the earliest
        write_policy(POLICY_FCFS);
        send_request(MODE_DEQ, 16'h5555, 31'h2AAAAAAA);
    endtask

    task automatic test_random_fcfs();
        write_policy(POLICY_FCFS);
        run_random_traffic(400);
    endtask

    task automatic test_random_sjf();
        write_policy(POLICY_SJF);
        run_random_traffic(400);
    endtask

    task automatic test_steady_stream();
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        write_policy(POLICY_SJF);
        run_random_traffic(400);
        sender_idle_on   = 1'b1;
        receiver_idle_on = 1'b1;
    endtask

    task automatic test_output_stall();
        write_policy(POLICY_SJF);
        hold_left = 400;
        run_random_burst(80, 80);
    endtask

    task automatic test_policy_switching();
        for (int round = 0; round < 8; round++)
        begin
            write_policy(round[0] ? POLICY_SJF : POLICY_FCFS);
            run_random_traffic(50);
        end
    endtask

    // result checker
    function automatic void check_field(input string name, input logic [31:0] exp,
                                        input logic [31:0] act);
        if (exp !== act)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp, act);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t exp;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("result beat with nothing expected");
                mismatches++;
            end
            else
            begin
                exp = expected_beats.pop_front();
                check_field("grant_valid", 32'(exp.grant_valid), 32'(m_tuser[0]));
                check_field("granted_tag", 32'(exp.tag), 32'(m_tdata[15:0]));
                check_field("granted_size", 32'(exp.size), 32'(m_tdata[46:16]));
                check_field("status", 32'(exp.status), 32'(m_tuser[2:1]));
                check_field("occupancy", 32'(exp.occupancy), 32'(m_tdata[51:47]));
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tuser          = 1'b0;
        m_tready         = 1'b0;
        cfg_valid        = 1'b0;
        cfg_data         = '0;
        held_count       = 0;
        grant_policy     = POLICY_FCFS;
        mismatches       = 0;
        cycle_count      = 0;
        hold_left        = 0;
        sender_idle_on   = 1'b1;
        receiver_idle_on = 1'b1;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_random_fcfs();
        test_random_sjf();
        test_steady_stream();
        test_output_stall();
        test_policy_switching();

        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_beats.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
